// ===== design/ghfp_pkg.sv =====
// Package for the gamepad hex frame parser: sizes, register indexes and the hex decoder.
`timescale 1ns / 1ps

package ghfp_pkg;

    // Default frame length in bytes: start byte, payload characters, end byte.
    localparam int FRAME_LENGTH_DEF = 18;

    // Payload characters that are decoded, and the stored fields they give.
    localparam int PAYLOAD_CHARS = 16;
    localparam int AXIS_COUNT    = 6;
    localparam int BUTTON_COUNT  = 4;

    // Quiet-time counter width; it stops at its all-ones value.
    localparam int QUIET_W = 17;
    localparam logic [QUIET_W-1:0] QUIET_MAX = {QUIET_W{1'b1}};

    // Full-scale axis value, used for the Y inversion.
    localparam logic [7:0] AXIS_FULL = 8'd255;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_MARKER     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_LEFT_Y  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_RIGHT_Y = 3'd4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Input item kinds.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Output beat layout.
    localparam int OUT_DATA_W = 72;

    // ASCII hex character to nibble; anything that is not hex gives zero.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

endpackage

// ===== design/gamepad_hex_frame_parser.sv =====
// Top level of the gamepad hex frame parser: byte window, frame match, decode, link watch.
`timescale 1ns / 1ps
// The result of an accepted input beat is registered and shows on the master side in the next cycle.
// Throughput: one item per cycle; the window shift and the hex decode sit between the
// input handshake and the result register, so a new beat is taken while a result waits
// only if the result register is being emptied in the same cycle.
// Reset (rst_n low, asynchronous): window empty, stored values zero, quiet time zero,
// start and end markers zero, timeout 1000 ticks, no Y inversion, no result pending.

module gamepad_hex_frame_parser
    import ghfp_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  logic                   s_tuser,   // [0] operation (0 byte, 1 tick)

    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] left_x, [15:8] left_y, [23:16] left_trigger, [31:24] right_x,
    // [39:32] right_y, [47:40] right_trigger, [51:48] dpad_nibble,
    // [55:52] misc_nibble, [59:56] shoulder_nibble, [63:60] face_nibble,
    // [64] link_ok, [71:65] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser,   // [0] frame_valid

    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int FILL_W = $clog2(FRAME_LENGTH + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_LENGTH);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_LENGTH - 1);

    // Configuration registers
    logic [7:0]   start_marker_reg;
    logic [7:0]   end_marker_reg;
    logic [15:0]  timeout_ticks_reg;
    logic         invert_left_y_reg;
    logic         invert_right_y_reg;

    // Parser state
    logic [7:0]        win_reg  [FRAME_LENGTH];
    logic [7:0]        win_next [FRAME_LENGTH];
    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    logic [7:0]        axis_reg    [AXIS_COUNT];
    logic [7:0]        axis_next   [AXIS_COUNT];
    logic [3:0]        button_reg  [BUTTON_COUNT];
    logic [3:0]        button_next [BUTTON_COUNT];
    logic [QUIET_W-1:0] quiet_reg;
    logic [QUIET_W-1:0] quiet_next;

    // Result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  out_frame_reg;

    logic       in_beat;
    logic       is_byte;
    logic       frame_match;
    logic [3:0] nib [PAYLOAD_CHARS];
    logic [7:0] left_y_out;
    logic [7:0] right_y_out;
    logic       link_ok_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign is_byte   = (s_tuser == OP_BYTE);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_frame_reg;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg   <= 8'd0;
            end_marker_reg     <= 8'd0;
            timeout_ticks_reg  <= TIMEOUT_RESET;
            invert_left_y_reg  <= 1'b0;
            invert_right_y_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_MARKER:   start_marker_reg   <= cfg_data[7:0];
                CFG_END_MARKER:     end_marker_reg     <= cfg_data[7:0];
                CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data;
                CFG_INVERT_LEFT_Y:  invert_left_y_reg  <= cfg_data[0];
                CFG_INVERT_RIGHT_Y: invert_right_y_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // The window always shifts the new byte in at the top. Once a full frame's worth of
    // bytes has arrived since the last refill, the window holds exactly those bytes.
    always_comb
    begin
        for (int i = 0; i < FRAME_LENGTH - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[FRAME_LENGTH - 1] = s_tdata;
    end

    // A byte matches when it fills the window and the markers sit at both ends.
    assign frame_match = is_byte && (fill_count_reg >= FILL_LAST)
                         && (win_next[0] == start_marker_reg)
                         && (s_tdata == end_marker_reg);

    // Hex decode of the payload characters that follow the start byte.
    always_comb
    begin
        for (int i = 0; i < PAYLOAD_CHARS; i++)
        begin
            nib[i] = hex_nibble(win_next[i + 1]);
        end
    end

    // Next values of the stores, the fill count and the quiet timer.
    always_comb
    begin
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            axis_next[i] = frame_match ? {nib[2 * i], nib[2 * i + 1]} : axis_reg[i];
        end
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            button_next[i] = frame_match ? nib[2 * AXIS_COUNT + i] : button_reg[i];
        end

        fill_count_next = fill_count_reg;
        quiet_next      = quiet_reg;
        if (frame_match)
        begin
            fill_count_next = '0;
            quiet_next      = '0;
        end
        else if (is_byte)
        begin
            if (fill_count_reg < FILL_FULL)
            begin
                fill_count_next = fill_count_reg + 1'b1;
            end
        end
        else if (quiet_reg != QUIET_MAX)
        begin
            quiet_next = quiet_reg + 1'b1;
        end
    end

    // Result beat: held values with the Y inversion applied, and the link state.
    assign left_y_out   = invert_left_y_reg  ? (AXIS_FULL - axis_next[1]) : axis_next[1];
    assign right_y_out  = invert_right_y_reg ? (AXIS_FULL - axis_next[4]) : axis_next[4];
    assign link_ok_next = (quiet_next <= {1'b0, timeout_ticks_reg});

    assign out_data_next = {7'd0, link_ok_next,
                            button_next[3], button_next[2], button_next[1], button_next[0],
                            axis_next[5], right_y_out, axis_next[3],
                            axis_next[2], left_y_out, axis_next[0]};

    // Window shift on byte beats only.
    always_ff @(posedge clk)
    begin
        if (in_beat && is_byte)
        begin
            for (int i = 0; i < FRAME_LENGTH; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Control state and stored frame fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            quiet_reg      <= '0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                axis_reg[i] <= 8'd0;
            end
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                button_reg[i] <= 4'd0;
            end
        end
        else if (in_beat)
        begin
            fill_count_reg <= fill_count_next;
            quiet_reg      <= quiet_next;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                axis_reg[i] <= axis_next[i];
            end
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                button_reg[i] <= button_next[i];
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            out_data_reg  <= out_data_next;
            out_frame_reg <= frame_match;
        end
    end

    // A completed frame always reports a good link.
    a_frame_link_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[64])
        else $error("frame result without link_ok");

    // A matched frame empties the window.
    a_match_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && frame_match) |=> (fill_count_reg == '0))
        else $error("window not emptied after a frame");

    // The fill count never passes the frame length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_FULL)
        else $error("fill count out of range");

    // A tick leaves the window untouched.
    a_tick_window: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !is_byte) |=> $stable(fill_count_reg))
        else $error("tick changed the window fill");

endmodule
